[hdl/fgrs_pkg.sv]
// Shared types and constants for the feed gap recovery sequencer.
// No dependencies; imported by every module of the block except fgrs_ram.
package fgrs_pkg;

  localparam int REORDER_DEPTH = 32;
  localparam int SEQ_BITS      = 32;
  localparam int IDX_W         = $clog2(REORDER_DEPTH);
  localparam int CNT_W         = $clog2(REORDER_DEPTH + 1);
  localparam int TYPE_W        = 3;
  localparam int OID_W         = 32;
  localparam int BODY_W        = 64;
  localparam int SLOT_W        = SEQ_BITS + TYPE_W + OID_W + BODY_W;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [TYPE_W-1:0] TYPE_CLEAR = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_START = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_ADD   = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_END   = 3'd3;

  typedef enum logic [2:0] {
    OP_INC   = 3'd0,
    OP_CLEAR = 3'd1,
    OP_START = 3'd2,
    OP_ADD   = 3'd3,
    OP_END   = 3'd4
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SEQ_BITS-1:0] seq;
    logic [TYPE_W-1:0]   utype;
    logic [OID_W-1:0]    oid;
    logic [BODY_W-1:0]   body;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DR_RD = 4'b0010,
    ST_DR_CK = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

endpackage

[hdl/fgrs_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fgrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/fgrs_front.sv]
// Front end: decodes incoming beats into operations and queues them.
// Depends on fgrs_pkg.
module fgrs_front
  import fgrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [SEQ_BITS-1:0] in_seq_num,
  input  logic [TYPE_W-1:0]   in_update_type,
  input  logic [OID_W-1:0]    in_order_id,
  input  logic [BODY_W-1:0]   in_payload,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             buf_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              keep;
  logic              push;
  item_t             dec;

  // Classify: snapshot kinds outside the cycle set carry no action, drop them here.
  always_comb begin
    dec.seq   = in_seq_num;
    dec.utype = in_update_type;
    dec.oid   = in_order_id;
    dec.body  = in_payload;
    dec.op    = OP_INC;
    keep      = 1'b1;
    if (in_cmd) begin
      case (in_update_type)
        TYPE_CLEAR: dec.op = OP_CLEAR;
        TYPE_START: dec.op = OP_START;
        TYPE_ADD:   dec.op = OP_ADD;
        TYPE_END:   dec.op = OP_END;
        default:    keep = 1'b0;
      endcase
    end
  end

  assign in_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[hdl/fgrs_back.sv]
// Back end: sequencing state, reorder window control, drain and sweep, output beat.
// Depends on fgrs_pkg; drives the reorder window RAM.
module fgrs_back
  import fgrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                ram_we,
  output logic [IDX_W-1:0]    ram_waddr,
  output logic [SLOT_W-1:0]   ram_wdata,
  output logic                ram_re,
  output logic [IDX_W-1:0]    ram_raddr,
  input  logic [SLOT_W-1:0]   ram_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TYPE_W-1:0]   out_type,
  output logic [OID_W-1:0]    out_order_id,
  output logic [BODY_W-1:0]   out_payload,
  output logic                out_last,
  output logic                out_recovering
);

  state_t                   state_r, state_nxt;
  logic                     rec_r, rec_nxt;
  logic                     armed_r, armed_nxt;
  logic                     active_r, active_nxt;
  logic [SEQ_BITS-1:0]      last_r, last_nxt;
  logic [SEQ_BITS-1:0]      exp_r, exp_nxt;
  logic [REORDER_DEPTH-1:0] valid_r, valid_nxt;
  logic                     hold_r, hold_nxt;
  logic [TYPE_W-1:0]        htype_r, htype_nxt;
  logic [OID_W-1:0]         hoid_r, hoid_nxt;
  logic [BODY_W-1:0]        hbody_r, hbody_nxt;
  logic [CNT_W-1:0]         sw_r, sw_nxt;
  logic                     ov_r, ov_nxt;
  logic [TYPE_W-1:0]        otype_r, otype_nxt;
  logic [OID_W-1:0]         ooid_r, ooid_nxt;
  logic [BODY_W-1:0]        obody_r, obody_nxt;
  logic                     olast_r, olast_nxt;
  logic                     orec_r, orec_nxt;

  logic                     can_push;
  logic [SEQ_BITS-1:0]      next_snap;
  logic [IDX_W-1:0]         exp_idx;
  logic [IDX_W-1:0]         sw_prev;
  logic [SEQ_BITS-1:0]      rtag;
  logic [TYPE_W-1:0]        rtype;
  logic [OID_W-1:0]         roid;
  logic [BODY_W-1:0]        rbody;
  logic                     hit;

  assign can_push  = !ov_r || out_ready;
  assign next_snap = last_r + 1'b1;
  assign exp_idx   = exp_r[IDX_W-1:0];
  assign sw_prev   = IDX_W'(sw_r - 1'b1);
  assign {rtag, rtype, roid, rbody} = ram_rdata;
  assign hit       = valid_r[exp_idx] && (rtag == exp_r);

  assign out_valid      = ov_r;
  assign out_type       = otype_r;
  assign out_order_id   = ooid_r;
  assign out_payload    = obody_r;
  assign out_last       = olast_r;
  assign out_recovering = orec_r;

  always_comb begin
    state_nxt  = state_r;
    rec_nxt    = rec_r;
    armed_nxt  = armed_r;
    active_nxt = active_r;
    last_nxt   = last_r;
    exp_nxt    = exp_r;
    valid_nxt  = valid_r;
    hold_nxt   = hold_r;
    htype_nxt  = htype_r;
    hoid_nxt   = hoid_r;
    hbody_nxt  = hbody_r;
    sw_nxt     = sw_r;
    ov_nxt     = ov_r && !out_ready;
    otype_nxt  = otype_r;
    ooid_nxt   = ooid_r;
    obody_nxt  = obody_r;
    olast_nxt  = olast_r;
    orec_nxt   = orec_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = q_item.seq[IDX_W-1:0];
    ram_wdata  = {q_item.seq, q_item.utype, q_item.oid, q_item.body};
    ram_re     = 1'b0;
    ram_raddr  = exp_idx;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && can_push) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_INC: begin
              if (rec_r) begin
                ram_we = 1'b1;
                valid_nxt[q_item.seq[IDX_W-1:0]] = 1'b1;
              end else if (q_item.seq == exp_r) begin
                hold_nxt  = 1'b1;
                htype_nxt = q_item.utype;
                hoid_nxt  = q_item.oid;
                hbody_nxt = q_item.body;
                exp_nxt   = exp_r + 1'b1;
                state_nxt = ST_DR_RD;
              end else if (q_item.seq > exp_r) begin
                ram_we = 1'b1;
                valid_nxt[q_item.seq[IDX_W-1:0]] = 1'b1;
                rec_nxt    = 1'b1;
                armed_nxt  = 1'b0;
                active_nxt = 1'b0;
                last_nxt   = '0;
              end
            end
            OP_CLEAR: begin
              if (rec_r) begin
                active_nxt = 1'b0;
                armed_nxt  = 1'b1;
                last_nxt   = q_item.seq;
                ov_nxt     = 1'b1;
                otype_nxt  = q_item.utype;
                ooid_nxt   = q_item.oid;
                obody_nxt  = q_item.body;
                olast_nxt  = 1'b1;
                orec_nxt   = 1'b1;
              end
            end
            OP_START: begin
              if (rec_r) begin
                if (armed_r && q_item.seq == next_snap) begin
                  active_nxt = 1'b1;
                  last_nxt   = q_item.seq;
                end else begin
                  active_nxt = 1'b0;
                end
                armed_nxt = 1'b0;
              end
            end
            OP_ADD: begin
              if (rec_r && active_r) begin
                if (q_item.seq == next_snap) begin
                  last_nxt  = q_item.seq;
                  ov_nxt    = 1'b1;
                  otype_nxt = q_item.utype;
                  ooid_nxt  = q_item.oid;
                  obody_nxt = q_item.body;
                  olast_nxt = 1'b1;
                  orec_nxt  = 1'b1;
                end else begin
                  active_nxt = 1'b0;
                end
              end
            end
            OP_END: begin
              if (rec_r && active_r) begin
                if (q_item.seq == next_snap) begin
                  last_nxt   = q_item.seq;
                  exp_nxt    = q_item.oid + 1'b1;
                  armed_nxt  = 1'b0;
                  active_nxt = 1'b0;
                  rec_nxt    = 1'b0;
                  hold_nxt   = 1'b0;
                  sw_nxt     = '0;
                  state_nxt  = ST_SWEEP;
                end else begin
                  active_nxt = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        // Read one slot a cycle; drop the slot read last cycle if it is older.
        if (sw_r < CNT_W'(REORDER_DEPTH)) begin
          ram_re    = 1'b1;
          ram_raddr = sw_r[IDX_W-1:0];
        end
        if (sw_r != '0) begin
          if (valid_r[sw_prev] && rtag < exp_r) begin
            valid_nxt[sw_prev] = 1'b0;
          end
        end
        if (sw_r == CNT_W'(REORDER_DEPTH)) begin
          state_nxt = ST_DR_RD;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end
      ST_DR_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_DR_CK;
      end
      ST_DR_CK: begin
        if (hit) begin
          if (!hold_r || can_push) begin
            if (hold_r) begin
              ov_nxt    = 1'b1;
              otype_nxt = htype_r;
              ooid_nxt  = hoid_r;
              obody_nxt = hbody_r;
              olast_nxt = 1'b0;
              orec_nxt  = rec_r;
            end
            hold_nxt           = 1'b1;
            htype_nxt          = rtype;
            hoid_nxt           = roid;
            hbody_nxt          = rbody;
            valid_nxt[exp_idx] = 1'b0;
            exp_nxt            = exp_r + 1'b1;
            state_nxt          = ST_DR_RD;
          end
        end else if (!hold_r) begin
          state_nxt = ST_IDLE;
        end else if (can_push) begin
          ov_nxt    = 1'b1;
          otype_nxt = htype_r;
          ooid_nxt  = hoid_r;
          obody_nxt = hbody_r;
          olast_nxt = 1'b1;
          orec_nxt  = rec_r;
          hold_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rec_r    <= 1'b0;
      armed_r  <= 1'b0;
      active_r <= 1'b0;
      last_r   <= '0;
      exp_r    <= SEQ_BITS'(1);
      valid_r  <= '0;
      hold_r   <= 1'b0;
      sw_r     <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rec_r    <= rec_nxt;
      armed_r  <= armed_nxt;
      active_r <= active_nxt;
      last_r   <= last_nxt;
      exp_r    <= exp_nxt;
      valid_r  <= valid_nxt;
      hold_r   <= hold_nxt;
      sw_r     <= sw_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    htype_r <= htype_nxt;
    hoid_r  <= hoid_nxt;
    hbody_r <= hbody_nxt;
    otype_r <= otype_nxt;
    ooid_r  <= ooid_nxt;
    obody_r <= obody_nxt;
    olast_r <= olast_nxt;
    orec_r  <= orec_nxt;
  end

endmodule

[hdl/feed_gap_recovery_sequencer.sv]
// Feed gap recovery sequencer top level: front decode queue, back sequencer, window RAM.
// Depends on fgrs_pkg, fgrs_front, fgrs_back, fgrs_ram.
// Path: an in-order beat passes the queue, the back end, a window RAM read and a hold
// check on its way out; each drained slot adds a RAM read and a tag check.
// Flow: the back end pops no new beat while it drains or sweeps; a snapshot end runs a
// sweep over all REORDER_DEPTH window RAM slots before its replay drain.
// Reset: synchronous active low; clears queue, valid bits and sequencing state.
module feed_gap_recovery_sequencer
  import fgrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [SEQ_BITS-1:0] in_seq_num,
  input  logic [TYPE_W-1:0]   in_update_type,
  input  logic [OID_W-1:0]    in_order_id,
  input  logic [BODY_W-1:0]   in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TYPE_W-1:0]   out_type,
  output logic [OID_W-1:0]    out_order_id,
  output logic [BODY_W-1:0]   out_payload,
  output logic                out_last,
  output logic                out_recovering
);

  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  // Front: classify beats and park up to QUEUE_DEPTH of them so the input side keeps moving
  // while the back end drains or sweeps, until the queue is full.
  fgrs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_seq_num     (in_seq_num),
    .in_update_type (in_update_type),
    .in_order_id    (in_order_id),
    .in_payload     (in_payload),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Back: hold the sequencing state, write gaps to the window, drain contiguous
  // slots, and sweep stale slots after a snapshot end.
  fgrs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_type       (out_type),
    .out_order_id   (out_order_id),
    .out_payload    (out_payload),
    .out_last       (out_last),
    .out_recovering (out_recovering)
  );

  // Reorder window: slot = seq mod depth, word = {tag, type, order id, payload}.
  fgrs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (REORDER_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[hdl/fgrs_checker.sv]
// Port-level checker for the feed gap recovery sequencer, bound to the top level.
// Depends on fgrs_pkg.
module fgrs_checker
  import fgrs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BODY_W-1:0] out_payload,
  input logic              out_last,
  input logic              out_recovering
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_payload))
    else $error("output payload changed while stalled");

  a_rec_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_recovering |-> out_last)
    else $error("beat during recovery not marked last");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind feed_gap_recovery_sequencer fgrs_checker u_fgrs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_payload    (out_payload),
  .out_last       (out_last),
  .out_recovering (out_recovering)
);

[test/tb_feed_gap_recovery_sequencer.sv]
// Testbench for feed_gap_recovery_sequencer: directed table plus random feed sequences.
// Depends on fgrs_pkg and the RTL top; checks every beat against a built-in predictor or typed row values.
`timescale 1ns / 1ps

module tb_feed_gap_recovery_sequencer;
  import fgrs_pkg::*;

  localparam logic CMD_INC  = 1'b0;
  localparam logic CMD_SNAP = 1'b1;
  localparam int   WIN      = REORDER_DEPTH;
  localparam int   N_RANDOM = 257;
  localparam int   LIMIT    = 600000;
  localparam int   USE_PRED = -1;  // row is checked by the predictor only

  typedef struct {
    logic [TYPE_W-1:0] utype;
    logic [OID_W-1:0]  oid;
    logic [BODY_W-1:0] body;
    logic              last;
    logic              rec;
  } fwd_t;

  typedef struct {
    logic                cmd;
    logic [SEQ_BITS-1:0] seq;
    logic [TYPE_W-1:0]   utype;
    logic [OID_W-1:0]    oid;
    logic [BODY_W-1:0]   body;
    int                  n_typed;  // USE_PRED, 0 (no beat) or 1 (one beat typed below)
    logic                e_rec;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_cmd;
  logic [SEQ_BITS-1:0] in_seq_num;
  logic [TYPE_W-1:0]   in_update_type;
  logic [OID_W-1:0]    in_order_id;
  logic [BODY_W-1:0]   in_payload;
  logic                out_valid;
  logic                out_ready;
  logic [TYPE_W-1:0]   out_type;
  logic [OID_W-1:0]    out_order_id;
  logic [BODY_W-1:0]   out_payload;
  logic                out_last;
  logic                out_recovering;

  feed_gap_recovery_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_seq_num(in_seq_num), .in_update_type(in_update_type),
    .in_order_id(in_order_id), .in_payload(in_payload),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_type(out_type), .out_order_id(out_order_id), .out_payload(out_payload),
    .out_last(out_last), .out_recovering(out_recovering)
  );

  // Predictor state: a mirror of the sequencer, window slots included.
  logic                mir_rec, mir_armed, mir_active;
  logic [SEQ_BITS-1:0] mir_snap_seq, mir_exp;
  logic                win_valid [WIN];
  logic [SEQ_BITS-1:0] win_tag   [WIN];
  logic [TYPE_W-1:0]   win_type  [WIN];
  logic [OID_W-1:0]    win_oid   [WIN];
  logic [BODY_W-1:0]   win_body  [WIN];

  fwd_t pending_fwd[$];  // beats still owed by the block, oldest first
  fwd_t step_fwd[$];     // beats caused by the item being predicted

  int errors;
  int accepted;
  int cycles;
  int idle_in_pct, stall_out_pct;
  bit hold_done;

  // Clock and cycle guard.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("feed_gap_recovery_sequencer: mismatch");
      $finish;
    end
  end

  function automatic int slot_idx(logic [SEQ_BITS-1:0] s);
    return int'(s % WIN);
  endfunction

  // Emit contiguous stored successors, at most one pass over the window.
  function automatic void replay_window();
    int s;
    for (int k = 0; k < WIN; k++) begin
      s = slot_idx(mir_exp);
      if (!win_valid[s] || win_tag[s] != mir_exp) break;
      step_fwd.push_back('{win_type[s], win_oid[s], win_body[s], 1'b0, 1'b0});
      win_valid[s] = 1'b0;
      mir_exp = mir_exp + 1'b1;
    end
  endfunction

  function automatic void park(logic [SEQ_BITS-1:0] s, logic [TYPE_W-1:0] t,
                               logic [OID_W-1:0] o, logic [BODY_W-1:0] b);
    int i;
    i = slot_idx(s);
    win_valid[i] = 1'b1;
    win_tag[i]   = s;
    win_type[i]  = t;
    win_oid[i]   = o;
    win_body[i]  = b;
  endfunction

  // Work out the beats one accepted item causes; they land in step_fwd.
  function automatic void predict_feed(logic cmd, logic [SEQ_BITS-1:0] s,
                                       logic [TYPE_W-1:0] t, logic [OID_W-1:0] o,
                                       logic [BODY_W-1:0] b);
    logic [SEQ_BITS-1:0] nxt;
    nxt = mir_snap_seq + 1'b1;
    step_fwd.delete();
    if (cmd == CMD_INC) begin
      if (mir_rec) begin
        park(s, t, o, b);
      end else if (s == mir_exp) begin
        step_fwd.push_back('{t, o, b, 1'b0, 1'b0});
        mir_exp = mir_exp + 1'b1;
        replay_window();
      end else if (s > mir_exp) begin
        park(s, t, o, b);
        mir_rec = 1'b1;
        mir_armed = 1'b0;
        mir_active = 1'b0;
        mir_snap_seq = '0;
      end
    end else if (mir_rec) begin
      case (t)
        TYPE_CLEAR: begin
          mir_active = 1'b0;
          mir_armed = 1'b1;
          mir_snap_seq = s;
          step_fwd.push_back('{t, o, b, 1'b0, 1'b0});
        end
        TYPE_START: begin
          mir_active = mir_armed && s == nxt;
          if (mir_active) mir_snap_seq = s;
          mir_armed = 1'b0;
        end
        TYPE_ADD: begin
          if (mir_active) begin
            if (s == nxt) begin
              step_fwd.push_back('{t, o, b, 1'b0, 1'b0});
              mir_snap_seq = s;
            end else begin
              mir_active = 1'b0;
            end
          end
        end
        TYPE_END: begin
          if (mir_active) begin
            if (s == nxt) begin
              // Resume after the snapshot point, drop older parked items, replay.
              mir_snap_seq = s;
              mir_exp = o + 1'b1;
              for (int i = 0; i < WIN; i++)
                if (win_valid[i] && win_tag[i] < mir_exp) win_valid[i] = 1'b0;
              replay_window();
              mir_armed = 1'b0;
              mir_active = 1'b0;
              mir_rec = 1'b0;
            end else begin
              mir_active = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
    foreach (step_fwd[i]) step_fwd[i].rec = mir_rec;
    if (step_fwd.size() > 0) step_fwd[step_fwd.size()-1].last = 1'b1;
  endfunction

  // Offer one beat, hold it until accepted, then queue its expected results.
  task automatic offer(logic cmd, logic [SEQ_BITS-1:0] s, logic [TYPE_W-1:0] t,
                       logic [OID_W-1:0] o, logic [BODY_W-1:0] b,
                       int n_typed = USE_PRED, logic e_rec = 1'b0);
    idle_in_pct   = accepted < 93 ? 13 : (accepted < 186 ? 66 : 0);
    stall_out_pct = accepted < 93 ? 66 : (accepted < 186 ? 13 : 0);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_seq_num     <= s;
    in_update_type <= t;
    in_order_id    <= o;
    in_payload     <= b;
    do @(posedge clk); while (!in_ready);
    accepted++;
    predict_feed(cmd, s, t, o, b);
    if (n_typed == USE_PRED) begin
      foreach (step_fwd[i]) pending_fwd.push_back(step_fwd[i]);
    end else if (n_typed == 1) begin
      pending_fwd.push_back('{t, o, b, 1'b1, e_rec});
    end
  endtask

  task automatic offer_noise();
    offer(1'($urandom), $urandom, 3'($urandom), $urandom, {$urandom, $urandom});
  endtask

  // Receiver: random stalls per phase, plus one long hold-off to back the block up.
  int hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted >= 200) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= stall_out_pct;
    end
  end

  // Checker: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    fwd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fwd.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: type %0d oid %h payload %h last %b rec %b",
                   out_type, out_order_id, out_payload, out_last, out_recovering);
      end else begin
        want = pending_fwd.pop_front();
        if (out_type !== want.utype || out_order_id !== want.oid ||
            out_payload !== want.body || out_last !== want.last ||
            out_recovering !== want.rec) begin
          errors++;
          if (errors <= 10)
            $display("beat differs: exp %0d/%h/%h/%b/%b got %0d/%h/%h/%b/%b",
                     want.utype, want.oid, want.body, want.last, want.rec,
                     out_type, out_order_id, out_payload, out_last, out_recovering);
        end
      end
    end
  end

  // Directed rows and the random feed.
  initial begin
    row_t rows[$];
    logic [SEQ_BITS-1:0] snap_s, end_oid;
    int r, n_add;
    bit broken;

    errors = 0; accepted = 0; cycles = 0; hold_done = 0; hold_left = 0;
    idle_in_pct = 13; stall_out_pct = 66;
    mir_rec = 0; mir_armed = 0; mir_active = 0; mir_snap_seq = '0; mir_exp = 1;
    for (int i = 0; i < WIN; i++) win_valid[i] = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_cmd = 1'b0; in_seq_num = '0;
    in_update_type = '0; in_order_id = '0; in_payload = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // In-order extremes, stale, ignored snapshots, gap, aborted and good snapshot cycles,
    // sequence wrap at the top of the range.
    rows = '{
      '{CMD_INC,  32'd1, 3'd4,       32'h0,        64'h0,  1, 1'b0},
      '{CMD_INC,  32'd2, 3'd7,       32'hFFFFFFFF, '1,     1, 1'b0},
      '{CMD_INC,  32'd1, 3'd2,       32'h5,        64'h5,  0, 1'b0},
      '{CMD_SNAP, 32'd9, TYPE_CLEAR, 32'h1,        64'h1,  0, 1'b0},
      '{CMD_INC,  32'd5, 3'd5,       32'h55,       64'h55, 0, 1'b0},
      '{CMD_INC,  32'd4, 3'd6,       32'h44,       64'h44, 0, 1'b0},
      '{CMD_SNAP, 32'd3, 3'd5,       32'h3,        64'h3,  0, 1'b0},
      '{CMD_SNAP, 32'd10, TYPE_START, 32'h0,       64'h0,  0, 1'b0},
      '{CMD_SNAP, 32'd20, TYPE_CLEAR, 32'h7,       64'hA5, 1, 1'b1},
      '{CMD_SNAP, 32'd21, TYPE_START, 32'h0,       64'h0,  0, 1'b0},
      '{CMD_SNAP, 32'd22, TYPE_ADD,   32'h9,       64'h99, 1, 1'b1},
      '{CMD_SNAP, 32'd24, TYPE_ADD,   32'hB,       64'hBB, 0, 1'b0},
      '{CMD_SNAP, 32'd25, TYPE_END,   32'h3,       64'h0,  0, 1'b0},
      '{CMD_SNAP, 32'd30, TYPE_CLEAR, 32'h0,       64'h0,  1, 1'b1},
      '{CMD_SNAP, 32'd31, TYPE_START, 32'h0,       64'h0,  0, 1'b0},
      '{CMD_SNAP, 32'd32, TYPE_ADD,   32'hC,       '1,     1, 1'b1},
      '{CMD_SNAP, 32'd33, TYPE_END,   32'h3,       64'h0,  USE_PRED, 1'b0},
      '{CMD_INC,  32'd6, 3'd1,       32'h66,       64'h66, 1, 1'b0},
      '{CMD_INC,  32'hFFFFFFFF, 3'd3, 32'h1,       64'h1,  0, 1'b0},
      '{CMD_SNAP, 32'hFFFFFFFF, TYPE_CLEAR, 32'h2, 64'h2,  1, 1'b1},
      '{CMD_SNAP, 32'h0, TYPE_START,  32'h0,       64'h0,  0, 1'b0},
      '{CMD_SNAP, 32'h1, TYPE_END,    32'hFFFFFFFF, 64'h0, USE_PRED, 1'b0},
      '{CMD_INC,  32'h0, 3'd0,       32'h0,        64'h0,  USE_PRED, 1'b0}
    };
    foreach (rows[i])
      offer(rows[i].cmd, rows[i].seq, rows[i].utype, rows[i].oid, rows[i].body,
            rows[i].n_typed, rows[i].e_rec);

    // Mostly well-formed feed: in-order runs, gaps, fills, snapshot cycles; some noise.
    while (accepted < N_RANDOM + rows.size()) begin
      r = $urandom_range(99);
      if (!mir_rec) begin
        if (r < 70)
          offer(CMD_INC, mir_exp, 3'($urandom), $urandom, {$urandom, $urandom});
        else if (r < 82)
          offer(CMD_INC, mir_exp + $urandom_range(1, 6), 3'($urandom), $urandom,
                {$urandom, $urandom});
        else if (r < 92)
          offer(CMD_INC, mir_exp - $urandom_range(1, 3), 3'($urandom), $urandom,
                {$urandom, $urandom});
        else
          offer_noise();
      end else if (r < 40) begin
        offer(CMD_INC, mir_exp + $urandom_range(0, 8), 3'($urandom), $urandom,
              {$urandom, $urandom});
      end else if (r < 90) begin
        snap_s = $urandom;
        broken = $urandom_range(99) < 15;
        n_add = $urandom_range(0, 4);
        offer(CMD_SNAP, snap_s, TYPE_CLEAR, $urandom, {$urandom, $urandom});
        snap_s++;
        offer(CMD_SNAP, snap_s, TYPE_START, $urandom, {$urandom, $urandom});
        for (int k = 0; k < n_add; k++) begin
          snap_s = snap_s + ((broken && k == 0) ? 2 : 1);
          offer(CMD_SNAP, snap_s, TYPE_ADD, $urandom, {$urandom, $urandom});
        end
        snap_s++;
        end_oid = mir_exp - 1 + $urandom_range(0, 6);
        offer(CMD_SNAP, snap_s, TYPE_END, end_oid, {$urandom, $urandom});
      end else begin
        offer_noise();
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed beat, then cover a sweep plus replay.
    while (pending_fwd.size() > 0) @(posedge clk);
    repeat (WIN * 3 + 20) @(posedge clk);
    if (errors == 0 && pending_fwd.size() == 0) begin
      $display("feed_gap_recovery_sequencer: match");
    end else begin
      $display("feed_gap_recovery_sequencer: mismatch");
    end
    $finish;
  end

endmodule
